// ----- hdl/rba_pkg.sv -----
// Shared types and constants of the guard-block bitmap allocator.
package rba_pkg;

  // Blocks that make up one region of a bank.
  localparam int BLOCKS_PER_REGION = 8;

  // Request kinds carried in the input tuser.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
  localparam logic [1:0] STATUS_NO_ROOM  = 2'd2;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BLOCK_SIZE_LOG2  = 2'd0;
  localparam logic [1:0] CFG_REGIONS_PER_BANK = 2'd1;
  localparam logic [1:0] CFG_BANK_A_BASE      = 2'd2;
  localparam logic [1:0] CFG_BANK_B_BASE      = 2'd3;

  // Bank select values.
  localparam logic BANK_A = 1'b0;
  localparam logic BANK_B = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_CHECK,
    ST_SCAN,
    ST_MARK,
    ST_GSHIFT,
    ST_FPREV,
    ST_FCUR,
    ST_FCLEAR,
    ST_DONE
  } state_t;

  // Access to the block bitmaps: which bank, and an optional bit write.
  typedef struct packed {
    logic bank;
    logic wr;
    logic wval;
  } bmap_cmd_t;

endpackage

// ----- hdl/rba_bitmap.sv -----
// Used-block bitmaps of both banks with one bit read and one bit write port.
module rba_bitmap #(
  parameter int MAX_BLOCKS = 64,
  parameter int IDX_W      = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rba_pkg::bmap_cmd_t   cmd,
  input  logic [IDX_W-1:0]     idx,
  output logic                 rd_bit
);

  logic [MAX_BLOCKS-1:0] map_a;
  logic [MAX_BLOCKS-1:0] map_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_a <= '0;
      map_b <= '0;
    end else if (cmd.wr) begin
      if (cmd.bank == rba_pkg::BANK_B) begin
        map_b[idx] <= cmd.wval;
      end else begin
        map_a[idx] <= cmd.wval;
      end
    end
  end

  assign rd_bit = (cmd.bank == rba_pkg::BANK_B) ? map_b[idx] : map_a[idx];

endmodule

// ----- hdl/redzone_bitmap_allocator_core.sv -----
// Top level of the guard-block bitmap allocator with two alternating banks.
// Allocate: shift the size down by block_size_log2, check it, scan the bank for a free run,
//   mark its inner blocks and shift the grant offset up; a bad size or no room ends early.
// Free: shift the address down, check it and the blocks around it, then clear the run.
// One request is in work at a time; the next is accepted once the result is registered.
// The bitmap scan takes one bit per cycle and the shift by block_size_log2 is serial.
// Reset (rst, synchronous): all blocks free, bank A marked last, registers to defaults.
module redzone_bitmap_allocator_core #(
  parameter int MAX_REGIONS_PER_BANK = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // request_size[31:0], free_address[63:32]
  input  logic [0:0]  s_axis_tuser,   // opcode[0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // status[1:0], granted_address[33:2], zero pad
);

  // Bitmap geometry follows from the largest bank this instance supports.
  localparam int MAX_BLOCKS = MAX_REGIONS_PER_BANK * rba_pkg::BLOCKS_PER_REGION;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  // Configuration registers.
  logic [4:0]  block_size_log2;
  logic [3:0]  regions_per_bank;
  logic [31:0] bank_a_base;
  logic [31:0] bank_b_base;

  // Control state.
  rba_pkg::state_t state;
  rba_pkg::state_t state_next;
  logic            last_bank;
  logic            out_valid;

  // Working registers of the request in progress.
  logic             op;
  logic [31:0]      sh;        // serial shift register: size, address, then grant offset
  logic             sticky;    // any one bit shifted out of sh on the way down
  logic [31:0]      off_a;     // address minus bank A base, shifted along with sh
  logic [31:0]      off_b;
  logic             gt_a;      // address strictly above the bank base
  logic             gt_b;
  logic [4:0]       cnt;       // remaining shift steps
  logic             bank_sel;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] run;
  logic [CNT_W-1:0] first;
  logic [CNT_W-1:0] need;
  logic [CNT_W-1:0] mark_end;
  logic [1:0]       res_status;
  logic [31:0]      res_addr;

  // Derived and combinational values.
  logic [3:0]         eff_regions;
  logic [CNT_W-1:0]   blocks;
  logic               cur_bit;
  logic               size_bad;
  logic               in_a;
  logic               in_b;
  logic [31:0]        free_idx;
  logic               free_bad;
  logic               scan_end;
  logic               found;
  logic               mark_done;
  logic               in_accept;
  logic               out_load;
  rba_pkg::bmap_cmd_t bmap_cmd;

  // Regions above what the bitmaps hold count as the maximum.
  assign eff_regions = (regions_per_bank > 4'(MAX_REGIONS_PER_BANK)) ?
                       4'(MAX_REGIONS_PER_BANK) : regions_per_bank;
  assign blocks = CNT_W'(eff_regions) * CNT_W'(rba_pkg::BLOCKS_PER_REGION);

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_load  = (state == rba_pkg::ST_DONE) && (!out_valid || m_axis_tready);

  // After the shift, sh holds size or address divided by the block size and sticky
  // tells whether the remainder was nonzero. A zero quotient with no remainder is zero.
  // A size of q blocks fits only if q + 2 blocks are available in the bank.
  assign size_bad = (sh == 32'd0) || sticky || (blocks == '0) ||
                    ((34'(sh) + 34'd2) > 34'(blocks));

  // The offset quotient below the block count is the same test as an address below
  // base plus bank size, since the bank size is a whole number of blocks.
  assign in_a = gt_a && (off_a < 32'(blocks));
  assign in_b = gt_b && (off_b < 32'(blocks));

  // Bank B wins where the two banks overlap.
  assign free_idx = in_b ? off_b : off_a;
  assign free_bad = (sh == 32'd0) || sticky || !(in_a || in_b) || (free_idx == 32'd0);

  assign scan_end  = (idx >= blocks);
  assign found     = !cur_bit && ((run + CNT_W'(1)) == need);
  assign mark_done = (idx == mark_end);

  rba_bitmap #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .IDX_W      (IDX_W)
  ) u_bitmap (
    .clk    (clk),
    .rst    (rst),
    .cmd    (bmap_cmd),
    .idx    (idx[IDX_W-1:0]),
    .rd_bit (cur_bit)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size_log2  <= 5'd5;
      regions_per_bank <= 4'd4;
      bank_a_base      <= 32'd0;
      bank_b_base      <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rba_pkg::CFG_BLOCK_SIZE_LOG2:  block_size_log2  <= cfg_data[4:0];
        rba_pkg::CFG_REGIONS_PER_BANK: regions_per_bank <= cfg_data[3:0];
        rba_pkg::CFG_BANK_A_BASE:      bank_a_base      <= cfg_data;
        rba_pkg::CFG_BANK_B_BASE:      bank_b_base      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rba_pkg::ST_IDLE: begin
        if (in_accept) state_next = rba_pkg::ST_SHIFT;
      end
      rba_pkg::ST_SHIFT: begin
        if (cnt == 5'd0) state_next = rba_pkg::ST_CHECK;
      end
      rba_pkg::ST_CHECK: begin
        if (op == rba_pkg::OP_ALLOC) begin
          state_next = size_bad ? rba_pkg::ST_DONE : rba_pkg::ST_SCAN;
        end else begin
          state_next = free_bad ? rba_pkg::ST_DONE : rba_pkg::ST_FPREV;
        end
      end
      rba_pkg::ST_SCAN: begin
        if (scan_end) state_next = rba_pkg::ST_DONE;
        else if (found) state_next = rba_pkg::ST_MARK;
      end
      rba_pkg::ST_MARK: begin
        if (mark_done) state_next = rba_pkg::ST_GSHIFT;
      end
      rba_pkg::ST_GSHIFT: begin
        if (cnt == 5'd0) state_next = rba_pkg::ST_DONE;
      end
      rba_pkg::ST_FPREV: begin
        state_next = cur_bit ? rba_pkg::ST_DONE : rba_pkg::ST_FCUR;
      end
      rba_pkg::ST_FCUR: begin
        state_next = cur_bit ? rba_pkg::ST_FCLEAR : rba_pkg::ST_DONE;
      end
      rba_pkg::ST_FCLEAR: begin
        if (scan_end || !cur_bit) state_next = rba_pkg::ST_DONE;
      end
      rba_pkg::ST_DONE: begin
        if (out_load) state_next = rba_pkg::ST_IDLE;
      end
      default: state_next = rba_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine: input ready and bitmap writes.
  always_comb begin
    s_axis_tready = (state == rba_pkg::ST_IDLE) && !rst;
    bmap_cmd.bank = bank_sel;
    bmap_cmd.wr   = 1'b0;
    bmap_cmd.wval = 1'b0;
    unique case (state)
      rba_pkg::ST_MARK: begin
        bmap_cmd.wr   = !mark_done;
        bmap_cmd.wval = 1'b1;
      end
      rba_pkg::ST_FCLEAR: begin
        bmap_cmd.wr   = !scan_end && cur_bit;
        bmap_cmd.wval = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rba_pkg::ST_IDLE;
      last_bank <= rba_pkg::BANK_A;
    end else begin
      state <= state_next;
      // The bank switches once the size is good, whether or not room is found.
      if ((state == rba_pkg::ST_CHECK) && (op == rba_pkg::OP_ALLOC) && !size_bad) begin
        last_bank <= ~last_bank;
      end
    end
  end

  // Datapath of the request in progress.
  always_ff @(posedge clk) begin
    case (state)
      rba_pkg::ST_IDLE: begin
        if (in_accept) begin
          op     <= s_axis_tuser[0];
          sh     <= (s_axis_tuser[0] == rba_pkg::OP_FREE) ?
                    s_axis_tdata[63:32] : s_axis_tdata[31:0];
          off_a  <= s_axis_tdata[63:32] - bank_a_base;
          off_b  <= s_axis_tdata[63:32] - bank_b_base;
          gt_a   <= s_axis_tdata[63:32] > bank_a_base;
          gt_b   <= s_axis_tdata[63:32] > bank_b_base;
          sticky <= 1'b0;
          cnt    <= block_size_log2;
        end
      end
      rba_pkg::ST_SHIFT: begin
        // Divide by the block size one bit per cycle.
        if (cnt != 5'd0) begin
          sh     <= {1'b0, sh[31:1]};
          sticky <= sticky | sh[0];
          off_a  <= {1'b0, off_a[31:1]};
          off_b  <= {1'b0, off_b[31:1]};
          cnt    <= cnt - 5'd1;
        end
      end
      rba_pkg::ST_CHECK: begin
        res_addr <= 32'd0;
        if (op == rba_pkg::OP_ALLOC) begin
          res_status <= rba_pkg::STATUS_BAD_SIZE;
          bank_sel   <= ~last_bank;
          need       <= sh[CNT_W-1:0] + CNT_W'(2);
          idx        <= '0;
          run        <= '0;
        end else begin
          res_status <= rba_pkg::STATUS_BAD_FREE;
          bank_sel   <= in_b ? rba_pkg::BANK_B : rba_pkg::BANK_A;
          // Start one block early to check that the previous block is clear.
          idx        <= free_idx[CNT_W-1:0] - CNT_W'(1);
        end
      end
      rba_pkg::ST_SCAN: begin
        // First-fit scan for a run of free blocks, one bit per cycle.
        if (scan_end) begin
          res_status <= rba_pkg::STATUS_NO_ROOM;
        end else if (found) begin
          mark_end <= idx;
          idx      <= first + CNT_W'(1);
        end else begin
          if (cur_bit) begin
            run <= '0;
          end else begin
            if (run == '0) first <= idx;
            run <= run + CNT_W'(1);
          end
          idx <= idx + CNT_W'(1);
        end
      end
      rba_pkg::ST_MARK: begin
        // Mark the inner blocks; the first and last block of the run stay clear.
        if (!mark_done) begin
          idx <= idx + CNT_W'(1);
        end else begin
          sh  <= 32'(first) + 32'd1;
          cnt <= block_size_log2;
        end
      end
      rba_pkg::ST_GSHIFT: begin
        // Scale the block number up to a byte offset one bit per cycle.
        if (cnt != 5'd0) begin
          sh  <= {sh[30:0], 1'b0};
          cnt <= cnt - 5'd1;
        end else begin
          res_status <= rba_pkg::STATUS_OK;
          res_addr   <= ((bank_sel == rba_pkg::BANK_B) ? bank_b_base : bank_a_base) + sh;
        end
      end
      rba_pkg::ST_FPREV: begin
        if (!cur_bit) idx <= idx + CNT_W'(1);
      end
      rba_pkg::ST_FCLEAR: begin
        // Clear until a clear block or the bank end.
        if (!scan_end && cur_bit) begin
          idx <= idx + CNT_W'(1);
        end else begin
          res_status <= rba_pkg::STATUS_OK;
        end
      end
      default: ;
    endcase
  end

  // Output register: a result waits here while the next request is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {6'd0, res_addr, res_status};
    end
  end

  assign m_axis_tvalid = out_valid;

endmodule

// ----- test/tb_redzone_bitmap_allocator_core.sv -----
// Self-checking testbench for the guard-block bitmap allocator core.
`timescale 1ns / 100ps

module tb_redzone_bitmap_allocator_core;

  localparam int MAX_REGIONS = 8;
  // Far above the slowest legal run of all requests with every stall.
  localparam int CYCLE_LIMIT = 2_000_000;

  // Keeps its own copy of the registers, both block bitmaps and the bank
  // toggle, computes the outcome of every accepted request and holds the
  // outcomes in order until the matching result beat shows up.
  class alloc_scoreboard;
    typedef struct packed {
      logic [1:0]  status;
      logic [31:0] granted;
    } outcome_t;

    logic [4:0]  blk_log2;
    logic [3:0]  region_count;
    logic [31:0] base_a;
    logic [31:0] base_b;
    logic [63:0] used_map [2];
    logic        last_bank;
    outcome_t    outcome_q [$];
    int          failures;

    function new();
      blk_log2     = 5'd5;
      region_count = 4'd4;
      base_a       = '0;
      base_b       = '0;
      used_map[0]  = '0;
      used_map[1]  = '0;
      last_bank    = rba_pkg::BANK_A;
      failures     = 0;
    endfunction

    function void set_reg(logic [1:0] index, logic [31:0] value);
      case (index)
        rba_pkg::CFG_BLOCK_SIZE_LOG2:  blk_log2     = value[4:0];
        rba_pkg::CFG_REGIONS_PER_BANK: region_count = value[3:0];
        rba_pkg::CFG_BANK_A_BASE:      base_a       = value;
        rba_pkg::CFG_BANK_B_BASE:      base_b       = value;
        default: ;
      endcase
    endfunction

    function logic [63:0] block_bytes();
      return 64'd1 << blk_log2;
    endfunction

    function int bank_blocks();
      return ((region_count > MAX_REGIONS) ? MAX_REGIONS : int'(region_count)) *
             rba_pkg::BLOCKS_PER_REGION;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) $display("mismatch: %s", what);
    endfunction

    // Start address of a random allocated area, for well-formed frees.
    function logic [31:0] live_area_start(output bit found);
      logic [31:0] starts [$];
      int          blocks;
      logic [63:0] bs;
      blocks = bank_blocks();
      bs     = block_bytes();
      for (int b = 0; b < 2; b++) begin
        for (int i = 1; i < blocks; i++) begin
          if (used_map[b][i] && !used_map[b][i-1])
            starts.push_back(32'(((b == 1) ? {32'd0, base_b} : {32'd0, base_a}) + bs * 64'(i)));
        end
      end
      found = (starts.size() > 0);
      return found ? starts[$urandom_range(0, starts.size() - 1)] : 32'd0;
    endfunction

    function void note_request(logic op, logic [31:0] size, logic [31:0] addr);
      logic [63:0] bs;
      logic [63:0] span;
      logic [63:0] base;
      logic [63:0] idx;
      logic [1:0]  status;
      logic [31:0] granted;
      logic        bank;
      int          blocks;
      int          need;
      int          run;
      int          first;
      bit          found;
      bit          hit;
      bs      = block_bytes();
      blocks  = bank_blocks();
      status  = rba_pkg::STATUS_OK;
      granted = '0;
      if (op == rba_pkg::OP_ALLOC) begin
        if (size == 0 || ({32'd0, size} & (bs - 1)) != 0 || blocks < 2 ||
            {32'd0, size} > bs * 64'(blocks - 2)) begin
          status = rba_pkg::STATUS_BAD_SIZE;
        end else begin
          // The bank flips even when the search comes up empty.
          need      = int'(size >> blk_log2) + 2;
          bank      = (last_bank == rba_pkg::BANK_A) ? rba_pkg::BANK_B : rba_pkg::BANK_A;
          last_bank = bank;
          base      = (bank == rba_pkg::BANK_B) ? {32'd0, base_b} : {32'd0, base_a};
          run       = 0;
          first     = 0;
          found     = 0;
          for (int i = 0; i < blocks && !found; i++) begin
            if (used_map[bank][i]) begin
              run = 0;
            end else begin
              if (run == 0) first = i;
              run++;
              if (run == need) begin
                // Outer blocks of the run stay clear as guards.
                for (int j = first + 1; j < i; j++) used_map[bank][j] = 1'b1;
                granted = 32'(base + bs * 64'(first + 1));
                found   = 1;
              end
            end
          end
          if (!found) status = rba_pkg::STATUS_NO_ROOM;
        end
      end else begin
        span = bs * 64'(blocks);
        if (addr == 0 || ({32'd0, addr} & (bs - 1)) != 0) begin
          status = rba_pkg::STATUS_BAD_FREE;
        end else begin
          hit  = 0;
          bank = rba_pkg::BANK_A;
          base = '0;
          if ({32'd0, addr} > {32'd0, base_a} && {32'd0, addr} < {32'd0, base_a} + span) begin
            hit  = 1;
            bank = rba_pkg::BANK_A;
            base = {32'd0, base_a};
          end
          // Bank B wins where the two banks overlap.
          if ({32'd0, addr} > {32'd0, base_b} && {32'd0, addr} < {32'd0, base_b} + span) begin
            hit  = 1;
            bank = rba_pkg::BANK_B;
            base = {32'd0, base_b};
          end
          if (!hit) begin
            status = rba_pkg::STATUS_BAD_FREE;
          end else begin
            idx = ({32'd0, addr} - base) >> blk_log2;
            if (idx == 0 || idx >= 64'(blocks) || !used_map[bank][idx[5:0]] ||
                used_map[bank][idx[5:0] - 6'd1]) begin
              status = rba_pkg::STATUS_BAD_FREE;
            end else begin
              while (idx < 64'(blocks) && used_map[bank][idx[5:0]]) begin
                used_map[bank][idx[5:0]] = 1'b0;
                idx++;
              end
            end
          end
        end
      end
      outcome_q.push_back('{status: status, granted: granted});
    endfunction

    function void check_result(logic [1:0] status, logic [31:0] granted);
      outcome_t want;
      if (outcome_q.size() == 0) begin
        flag($sformatf("result beat with nothing pending: status %0d address %h",
                       status, granted));
        return;
      end
      want = outcome_q.pop_front();
      if (status !== want.status)
        flag($sformatf("status: wanted %0d, got %0d", want.status, status));
      if (granted !== want.granted)
        flag($sformatf("granted address: wanted %h, got %h", want.granted, granted));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // request_size[31:0], free_address[63:32]
  logic [0:0]  s_axis_tuser = '0;   // opcode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // status[1:0], granted_address[33:2], zero pad

  alloc_scoreboard sb = new();

  // When clear, neither the request side nor the result side idles.
  bit bursts_on = 1'b1;
  int stall_left = 0;
  int cycles = 0;

  redzone_bitmap_allocator_core #(
    .MAX_REGIONS_PER_BANK(MAX_REGIONS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side. Values read right at the edge are the ones the block saw
  // there, so a beat counts when both tvalid and tready read high. The ready
  // line drops in random bursts while bursts are enabled.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[1:0], m_axis_tdata[33:2]);
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Presents one request and returns at the edge that accepted it. tvalid is
  // left high so the caller can put the next beat up in the same step
  // without dropping it first.
  task automatic send_request(input logic op, input logic [31:0] size,
                              input logic [31:0] addr);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {addr, size};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(op, size, addr);
  endtask

  // Registers only change with no request in flight: drain every pending
  // result, let the block settle, then write all four.
  task automatic reconfigure(input logic [4:0] lg, input logic [3:0] regions,
                             input logic [31:0] a_base, input logic [31:0] b_base);
    logic [31:0] values [4];
    values[rba_pkg::CFG_BLOCK_SIZE_LOG2]  = {27'd0, lg};
    values[rba_pkg::CFG_REGIONS_PER_BANK] = {28'd0, regions};
    values[rba_pkg::CFG_BANK_A_BASE]      = a_base;
    values[rba_pkg::CFG_BANK_B_BASE]      = b_base;
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= values[i];
      @(posedge clk);
      sb.set_reg(2'(i), values[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed traffic: allocations of small multiples of the block
  // size and frees of live areas, with malformed sizes and stray addresses
  // mixed in. The field a request does not use still carries random bits.
  task automatic send_random_request();
    logic        op;
    logic [31:0] size;
    logic [31:0] addr;
    logic [63:0] bs;
    int          maxk;
    int          pick;
    bit          found;
    bs   = sb.block_bytes();
    maxk = sb.bank_blocks() - 2;
    pick = $urandom_range(0, 99);
    op   = rba_pkg::OP_ALLOC;
    size = $urandom();
    addr = $urandom();
    if (pick < 50) begin
      if (maxk < 1)
        size = 32'(bs);
      else if (pick < 40)
        size = 32'(bs * 64'($urandom_range(1, (maxk < 4) ? maxk : 4)));
      else
        size = 32'(bs * 64'($urandom_range(1, maxk)));
    end else if (pick < 85) begin
      op   = rba_pkg::OP_FREE;
      addr = sb.live_area_start(found);
      if (!found) addr = 32'(bs);
    end else if (pick < 92) begin
      case ($urandom_range(0, 3))
        0: size = '0;
        1: size = 32'(bs) + 32'($urandom_range(1, 31));
        2: size = 32'(bs * 64'(maxk + 1));
        default: ;
      endcase
    end else begin
      op   = rba_pkg::OP_FREE;
      addr = sb.live_area_start(found);
      case ($urandom_range(0, 3))
        // Points into the middle of an area or at a guard block.
        0: addr = addr + 32'(bs);
        1: addr = addr + 32'($urandom_range(1, 31));
        2: addr = '0;
        default: addr = $urandom();
      endcase
    end
    send_request(op, size, addr);
  endtask

  task automatic run_phase(input logic [4:0] lg, input logic [3:0] regions,
                           input logic [31:0] a_base, input logic [31:0] b_base,
                           input int count);
    reconfigure(lg, regions, a_base, b_base);
    repeat (count) send_random_request();
  endtask

  initial begin
    logic [4:0]  lg;
    logic [31:0] mask;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: 32-byte blocks, 32 blocks per bank, both banks at zero.
    send_request(rba_pkg::OP_ALLOC, 32'd0, $urandom());          // zero size
    send_request(rba_pkg::OP_ALLOC, 32'd33, $urandom());         // not a block multiple
    send_request(rba_pkg::OP_ALLOC, 32'hFFFF_FFFF, $urandom());  // far too large
    send_request(rba_pkg::OP_ALLOC, 32'd992, $urandom());        // one block over the limit
    send_request(rba_pkg::OP_ALLOC, 32'd960, $urandom());        // fills bank B
    send_request(rba_pkg::OP_ALLOC, 32'd32, $urandom());         // goes to bank A
    send_request(rba_pkg::OP_ALLOC, 32'd32, $urandom());         // bank B has no room
    send_request(rba_pkg::OP_FREE, $urandom(), 32'd0);           // zero address
    send_request(rba_pkg::OP_FREE, $urandom(), 32'd33);          // unaligned
    // Banks overlap, so this frees the full run in bank B.
    send_request(rba_pkg::OP_FREE, $urandom(), 32'd32);
    send_request(rba_pkg::OP_FREE, $urandom(), 32'd32);          // block already clear
    send_request(rba_pkg::OP_FREE, $urandom(), 32'd64);
    send_request(rba_pkg::OP_FREE, $urandom(), 32'd1024);        // past the bank end

    // Largest blocks, regions above the maximum, bank A near the top so the
    // granted address wraps.
    reconfigure(5'd16, 4'd15, 32'hFFFF_0000, 32'h8000_0000);
    send_request(rba_pkg::OP_ALLOC, 32'h0002_0000, $urandom());
    send_request(rba_pkg::OP_ALLOC, 32'h003E_0000, $urandom());
    send_request(rba_pkg::OP_FREE, $urandom(), 32'h8002_0000);   // previous block in use
    send_request(rba_pkg::OP_FREE, $urandom(), 32'h8001_0000);

    // No regions at all: every request is refused.
    reconfigure(5'd5, 4'd0, 32'h0000_0000, 32'h0000_4000);
    send_request(rba_pkg::OP_ALLOC, 32'd32, $urandom());
    send_request(rba_pkg::OP_FREE, $urandom(), 32'h0000_4020);

    // A wide area in bank B, then the bank shrinks under it so the free runs
    // into the bank end.
    reconfigure(5'd5, 4'd8, 32'h0000_0000, 32'h0000_4000);
    send_request(rba_pkg::OP_ALLOC, 32'd448, $urandom());
    send_request(rba_pkg::OP_ALLOC, 32'd448, $urandom());
    reconfigure(5'd5, 4'd1, 32'h0000_0000, 32'h0000_4000);
    send_request(rba_pkg::OP_FREE, $urandom(), 32'h0000_4020);

    // Random traffic under a range of settings. Bitmaps carry over from one
    // setting to the next, so shrinking banks and stale areas get exercised.
    run_phase(5'd5, 4'd4, 32'h0000_1000, 32'h0000_2000, 200);
    run_phase(5'd16, 4'd8, 32'h1000_0000, 32'hFFE0_0000, 200);
    run_phase(5'd8, 4'd1, 32'h0000_0000, 32'h0000_0100, 200);
    lg   = 5'($urandom_range(5, 16));
    mask = ~((32'd1 << lg) - 32'd1);
    run_phase(lg, 4'($urandom_range(1, 8)), $urandom() & mask, $urandom() & mask, 200);
    run_phase(5'd12, 4'd15, 32'hFFFF_FFFF, 32'h4000_0000, 200);
    bursts_on = 1'b0;
    run_phase(5'd5, 4'd8, 32'h8000_0000, 32'h8000_0800, 250);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
